[rtl/ctc_pkg.sv]
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared constants, codes and control structs of the completion tracker.
// ----------------------------------------------------------------------------
package ctc_pkg;

    localparam int PIN_DEPTH   = 64;
    localparam int RANGE_DEPTH = 16;

    localparam int PIN_AW   = $clog2(PIN_DEPTH);
    localparam int PIN_CW   = $clog2(PIN_DEPTH + 1);
    localparam int RANGE_AW = $clog2(RANGE_DEPTH);
    localparam int RANGE_CW = $clog2(RANGE_DEPTH + 2);

    localparam int ID_W    = 64;
    localparam int BYTES_W = 48;
    localparam int PIN_MW  = ID_W + 32;
    localparam int RANGE_MW = 2 * ID_W;

    localparam logic [ID_W-1:0] ID_WRAP = 64'h0000_0001_0000_0000;
    localparam logic [PIN_AW-1:0] PIN_LAST = PIN_AW'(PIN_DEPTH - 1);
    localparam logic [PIN_CW-1:0] PIN_FULL = PIN_CW'(PIN_DEPTH);
    localparam logic [RANGE_CW-1:0] RANGE_LIM = RANGE_CW'(RANGE_DEPTH);
    localparam logic [RANGE_CW-1:0] RANGE_OVF = RANGE_CW'(RANGE_DEPTH + 1);

    localparam logic [1:0] CMD_SUBMIT = 2'd0;
    localparam logic [1:0] CMD_NOTICE = 2'd1;
    localparam logic [1:0] CMD_CLOSE  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_PIN_FULL   = 3'd1;
    localparam logic [2:0] ST_RANGE_FULL = 3'd2;
    localparam logic [2:0] ST_MALFORMED  = 3'd3;
    localparam logic [2:0] ST_RETIRED    = 3'd4;

    typedef struct packed {
        logic            start;
        logic            clear;
        logic [ID_W-1:0] s;
        logic [ID_W-1:0] e;
        logic [ID_W-1:0] rp;
    } t_range_req;

    typedef struct packed {
        logic            done;
        logic            ovf;
        logic            first;
        logic [ID_W-1:0] new_rp;
    } t_range_rsp;

    typedef struct packed {
        logic            push;
        logic            clear;
        logic            pop;
        logic [ID_W-1:0] last_id;
        logic [31:0]     size;
        logic [ID_W-1:0] rp;
    } t_pin_req;

    typedef struct packed {
        logic               done;
        logic [PIN_CW-1:0]  count;
        logic [BYTES_W-1:0] pinned;
        logic [PIN_CW-1:0]  completed;
        logic [BYTES_W-1:0] retired;
    } t_pin_rsp;

endpackage

[rtl/ctc_if.sv]
// ----------------------------------------------------------------------------
// ctc_in_if / ctc_out_if
// Valid/ready channels carrying one input word and one result word.
// ----------------------------------------------------------------------------
interface ctc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  id_count;
    logic [31:0] pin_bytes;
    logic [31:0] range_low;
    logic [31:0] range_high;
    logic        was_copied;

    modport source (output valid, command, id_count, pin_bytes, range_low, range_high,
                    was_copied, input ready);
    modport sink (input valid, command, id_count, pin_bytes, range_low, range_high,
                  was_copied, output ready);
endinterface

interface ctc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [6:0]  pins_completed;
    logic [47:0] bytes_retired;
    logic [32:0] fallback_ids;
    logic [6:0]  pins_dropped;
    logic [47:0] pinned_total;
    logic [6:0]  pending_pins;

    modport source (output valid, status, pins_completed, bytes_retired, fallback_ids,
                    pins_dropped, pinned_total, pending_pins, input ready);
    modport sink (input valid, status, pins_completed, bytes_retired, fallback_ids,
                  pins_dropped, pinned_total, pending_pins, output ready);
endinterface

[rtl/ctc_ram.sv]
// ----------------------------------------------------------------------------
// ctc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ctc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ctc_range_merge.sv]
// ----------------------------------------------------------------------------
// ctc_range_merge
// Sorted range table in a two-bank RAM. A merge streams the live bank,
// inserts the new range, coalesces, and writes the result to the other bank.
// ----------------------------------------------------------------------------
module ctc_range_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ctc_pkg::t_range_req i_req,
    output ctc_pkg::t_range_rsp o_rsp
);

    localparam logic [1:0] R_IDLE  = 2'd0;
    localparam logic [1:0] R_RUN   = 2'd1;
    localparam logic [1:0] R_FLUSH = 2'd2;
    localparam logic [1:0] R_DONE  = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic                         r_bank, n_bank;
    logic [ctc_pkg::RANGE_CW-1:0] r_used, n_used;
    logic [ctc_pkg::RANGE_CW-1:0] r_cons, n_cons;
    logic [ctc_pkg::RANGE_CW-1:0] r_cnt, n_cnt;
    logic                         r_placed, n_placed;
    logic                         r_cur_v, n_cur_v;
    logic                         r_any, n_any;
    logic                         r_first, n_first;
    logic [ctc_pkg::ID_W-1:0]     r_cs, n_cs, r_ce, n_ce;
    logic [ctc_pkg::ID_W-1:0]     r_s, n_s, r_e, n_e, r_rp, n_rp, r_nrp, n_nrp;

    logic                           w_we, w_re;
    logic [ctc_pkg::RANGE_AW:0]     w_waddr, w_raddr;
    logic [ctc_pkg::RANGE_MW-1:0]   w_wdata, w_rdata;
    logic [ctc_pkg::RANGE_CW-1:0]   w_cons_nx;
    logic [ctc_pkg::ID_W-1:0]       w_old_s, w_old_e, w_es, w_ee;
    logic                           w_old_av, w_take_new, w_elem_v, w_tch, w_emit;

    ctc_ram #(
        .WIDTH(ctc_pkg::RANGE_MW),
        .DEPTH(2 << ctc_pkg::RANGE_AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_old_s   = w_rdata[ctc_pkg::RANGE_MW-1:ctc_pkg::ID_W];
    assign w_old_e   = w_rdata[ctc_pkg::ID_W-1:0];
    assign w_cons_nx = r_cons + 1'b1;

    always_comb begin
        n_state  = r_state;
        n_bank   = r_bank;
        n_used   = r_used;
        n_cons   = r_cons;
        n_cnt    = r_cnt;
        n_placed = r_placed;
        n_cur_v  = r_cur_v;
        n_any    = r_any;
        n_first  = r_first;
        n_cs     = r_cs;
        n_ce     = r_ce;
        n_s      = r_s;
        n_e      = r_e;
        n_rp     = r_rp;
        n_nrp    = r_nrp;
        w_re     = 1'b0;
        w_raddr  = {r_bank, w_cons_nx[ctc_pkg::RANGE_AW-1:0]};
        w_we     = 1'b0;
        w_waddr  = {~r_bank, r_cnt[ctc_pkg::RANGE_AW-1:0]};
        w_wdata  = {r_cs, r_ce};
        w_old_av   = r_cons < r_used;
        w_take_new = !r_placed && (!w_old_av || w_old_s > r_s);
        w_elem_v   = w_take_new || w_old_av;
        w_es       = w_take_new ? r_s : w_old_s;
        w_ee       = w_take_new ? r_e : w_old_e;
        w_tch      = r_cur_v && (r_ce == '1 || w_es <= r_ce + 1'b1);
        w_emit     = 1'b0;
        o_rsp      = '0;

        unique case (r_state)
            R_IDLE: begin
                if (i_req.start) begin
                    n_s      = i_req.s;
                    n_e      = i_req.e;
                    n_rp     = i_req.rp;
                    n_cons   = '0;
                    n_cnt    = '0;
                    n_placed = 1'b0;
                    n_cur_v  = 1'b0;
                    n_any    = 1'b0;
                    n_first  = 1'b0;
                    w_re     = 1'b1;
                    w_raddr  = {r_bank, {ctc_pkg::RANGE_AW{1'b0}}};
                    n_state  = R_RUN;
                end
            end
            R_RUN: begin
                if (!w_elem_v) begin
                    n_state = R_FLUSH;
                end else begin
                    w_emit = r_cur_v && !w_tch;
                    if (w_tch) begin
                        if (w_ee > r_ce) begin
                            n_ce = w_ee;
                        end
                    end else begin
                        n_cs    = w_es;
                        n_ce    = w_ee;
                        n_cur_v = 1'b1;
                    end
                    if (w_take_new) begin
                        n_placed = 1'b1;
                    end else begin
                        n_cons = w_cons_nx;
                        w_re   = 1'b1;
                    end
                end
            end
            R_FLUSH: begin
                w_emit  = 1'b1;
                n_state = R_DONE;
            end
            R_DONE: begin
                o_rsp.done   = 1'b1;
                o_rsp.ovf    = r_cnt > ctc_pkg::RANGE_LIM;
                o_rsp.first  = r_first;
                o_rsp.new_rp = r_nrp;
                if (r_cnt <= ctc_pkg::RANGE_LIM) begin
                    n_bank = ~r_bank;
                    n_used = r_cnt;
                end
                n_state = R_IDLE;
            end
            default: n_state = R_IDLE;
        endcase

        if (w_emit) begin
            n_any = 1'b1;
            if (!r_any && r_cs <= r_rp) begin
                n_first = 1'b1;
                n_nrp   = r_ce + 1'b1;
            end else begin
                w_we = r_cnt < ctc_pkg::RANGE_LIM;
                if (r_cnt != ctc_pkg::RANGE_OVF) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
        end

        if (i_req.clear) begin
            n_used = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
            r_bank  <= 1'b0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
            r_used  <= n_used;
        end
        r_cons   <= n_cons;
        r_cnt    <= n_cnt;
        r_placed <= n_placed;
        r_cur_v  <= n_cur_v;
        r_any    <= n_any;
        r_first  <= n_first;
        r_cs     <= n_cs;
        r_ce     <= n_ce;
        r_s      <= n_s;
        r_e      <= n_e;
        r_rp     <= n_rp;
        r_nrp    <= n_nrp;
    end

endmodule

[rtl/ctc_pin_queue.sv]
// ----------------------------------------------------------------------------
// ctc_pin_queue
// Circular queue of pins in RAM with pinned-byte accounting. Pops walk the
// head one pin a cycle while its last id lies below the retire point.
// ----------------------------------------------------------------------------
module ctc_pin_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctc_pkg::t_pin_req i_req,
    output ctc_pkg::t_pin_rsp o_rsp
);

    logic                        r_chk, n_chk;
    logic [ctc_pkg::PIN_AW-1:0]  r_head, n_head;
    logic [ctc_pkg::PIN_CW-1:0]  r_count, n_count;
    logic [ctc_pkg::BYTES_W-1:0] r_pinned, n_pinned;
    logic [ctc_pkg::PIN_CW-1:0]  r_completed, n_completed;
    logic [ctc_pkg::BYTES_W-1:0] r_retired, n_retired;

    logic                        w_we, w_re;
    logic [ctc_pkg::PIN_AW-1:0]  w_raddr, w_tail, w_head_nx;
    logic [ctc_pkg::PIN_CW:0]    w_sum;
    logic [ctc_pkg::PIN_MW-1:0]  w_rdata;
    logic [ctc_pkg::ID_W-1:0]    w_last;
    logic [31:0]                 w_size;
    logic [ctc_pkg::BYTES_W:0]   w_add;

    ctc_ram #(
        .WIDTH(ctc_pkg::PIN_MW),
        .DEPTH(ctc_pkg::PIN_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_tail),
        .i_wdata({i_req.last_id, i_req.size}),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_last    = w_rdata[ctc_pkg::PIN_MW-1:32];
    assign w_size    = w_rdata[31:0];
    assign w_sum     = (ctc_pkg::PIN_CW + 1)'(r_head) + (ctc_pkg::PIN_CW + 1)'(r_count);
    assign w_tail    = (w_sum >= (ctc_pkg::PIN_CW + 1)'(ctc_pkg::PIN_DEPTH))
                     ? ctc_pkg::PIN_AW'(w_sum - (ctc_pkg::PIN_CW + 1)'(ctc_pkg::PIN_DEPTH))
                     : ctc_pkg::PIN_AW'(w_sum);
    assign w_head_nx = (r_head == ctc_pkg::PIN_LAST) ? '0 : r_head + 1'b1;
    assign w_add     = {1'b0, r_pinned} + (ctc_pkg::BYTES_W + 1)'(i_req.size);
    assign w_we      = i_req.push;

    always_comb begin
        n_chk       = r_chk;
        n_head      = r_head;
        n_count     = r_count;
        n_pinned    = r_pinned;
        n_completed = r_completed;
        n_retired   = r_retired;
        w_re        = 1'b0;
        w_raddr     = r_head;
        o_rsp           = '0;
        o_rsp.count     = r_count;
        o_rsp.pinned    = r_pinned;
        o_rsp.completed = r_completed;
        o_rsp.retired   = r_retired;

        if (i_req.push) begin
            n_count  = r_count + 1'b1;
            n_pinned = w_add[ctc_pkg::BYTES_W] ? '1 : w_add[ctc_pkg::BYTES_W-1:0];
        end
        if (i_req.pop) begin
            w_re        = 1'b1;
            n_completed = '0;
            n_retired   = '0;
            n_chk       = 1'b1;
        end
        if (r_chk) begin
            if (r_count != '0 && w_last < i_req.rp) begin
                n_head      = w_head_nx;
                n_count     = r_count - 1'b1;
                n_completed = r_completed + 1'b1;
                n_retired   = r_retired + ctc_pkg::BYTES_W'(w_size);
                n_pinned    = (r_pinned >= ctc_pkg::BYTES_W'(w_size))
                            ? r_pinned - ctc_pkg::BYTES_W'(w_size) : '0;
                w_re        = 1'b1;
                w_raddr     = w_head_nx;
            end else begin
                o_rsp.done = 1'b1;
                n_chk      = 1'b0;
            end
        end
        if (i_req.clear) begin
            n_head   = '0;
            n_count  = '0;
            n_pinned = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk    <= 1'b0;
            r_head   <= '0;
            r_count  <= '0;
            r_pinned <= '0;
        end else begin
            r_chk    <= n_chk;
            r_head   <= n_head;
            r_count  <= n_count;
            r_pinned <= n_pinned;
        end
        r_completed <= n_completed;
        r_retired   <= n_retired;
    end

endmodule

[rtl/zerocopy_completion_tracker.sv]
// ----------------------------------------------------------------------------
// zerocopy_completion_tracker
// Tracks zero-copy pins until out-of-order completion ranges retire them.
// ----------------------------------------------------------------------------
// Use: words enter on i_in (valid/ready), one result word per input word
// leaves on o_out (valid/ready). Commands are submit, completion notice and
// close. One word is in flight at a time.
// Flow: submit, close and unknown commands are decoded, then go to the output
// register. A notice is range-checked first; a malformed or already retired
// one then goes to output, an accepted one runs a merge (streaming the range
// RAM one entry a cycle) and then pops pins (the pin RAM head is walked one
// pin a cycle). A notice refused for a full range table pops no pins.
// Reset (synchronous, i_rst_n low) empties the pin queue and range table and
// zeroes the id counter and retire point; no clearing pass is needed.
// A stalled receiver holds the result in the output register; the next word
// is still accepted and processed, and waits for that register to free up.
// ----------------------------------------------------------------------------
module zerocopy_completion_tracker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ctc_in_if.sink    i_in,
    ctc_out_if.source o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_POP   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]               r_state, n_state;
    logic [1:0]               r_cmd, n_cmd;
    logic [7:0]               r_idc, n_idc;
    logic [31:0]              r_bytes, n_bytes;
    logic [31:0]              r_lo32, n_lo32, r_hi32, n_hi32;
    logic                     r_copied, n_copied;
    logic [ctc_pkg::ID_W-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [ctc_pkg::ID_W-1:0] r_next_id, n_next_id, r_rp, n_rp;
    logic [2:0]               r_status, n_status;
    logic [32:0]              r_fallback, n_fallback;
    logic [6:0]               r_dropped, n_dropped;
    logic                     r_popped, n_popped;

    logic        r_o_valid, n_o_valid;
    logic [2:0]  r_o_status, n_o_status;
    logic [6:0]  r_o_completed, n_o_completed;
    logic [47:0] r_o_retired, n_o_retired;
    logic [32:0] r_o_fallback, n_o_fallback;
    logic [6:0]  r_o_dropped, n_o_dropped;
    logic [47:0] r_o_pinned, n_o_pinned;
    logic [6:0]  r_o_pending, n_o_pending;

    ctc_pkg::t_range_req w_rreq;
    ctc_pkg::t_range_rsp w_rrsp;
    ctc_pkg::t_pin_req   w_preq;
    ctc_pkg::t_pin_rsp   w_prsp;

    logic [ctc_pkg::ID_W-1:0] w_lo, w_hi;

    ctc_range_merge u_range (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_rreq),
        .o_rsp  (w_rrsp)
    );

    ctc_pin_queue u_pins (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_preq),
        .o_rsp  (w_prsp)
    );

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_o_valid;
    assign o_out.status         = r_o_status;
    assign o_out.pins_completed = r_o_completed;
    assign o_out.bytes_retired  = r_o_retired;
    assign o_out.fallback_ids   = r_o_fallback;
    assign o_out.pins_dropped   = r_o_dropped;
    assign o_out.pinned_total   = r_o_pinned;
    assign o_out.pending_pins   = r_o_pending;

    always_comb begin
        w_lo = {r_rp[63:32], r_lo32};
        if (w_lo < r_rp) begin
            w_lo = w_lo + ctc_pkg::ID_WRAP;
        end
        w_hi = {r_rp[63:32], r_hi32};
        if (w_hi < r_rp) begin
            w_hi = w_hi + ctc_pkg::ID_WRAP;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idc      = r_idc;
        n_bytes    = r_bytes;
        n_lo32     = r_lo32;
        n_hi32     = r_hi32;
        n_copied   = r_copied;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_next_id  = r_next_id;
        n_rp       = r_rp;
        n_status   = r_status;
        n_fallback = r_fallback;
        n_dropped  = r_dropped;
        n_popped   = r_popped;

        n_o_valid     = r_o_valid && !o_out.ready;
        n_o_status    = r_o_status;
        n_o_completed = r_o_completed;
        n_o_retired   = r_o_retired;
        n_o_fallback  = r_o_fallback;
        n_o_dropped   = r_o_dropped;
        n_o_pinned    = r_o_pinned;
        n_o_pending   = r_o_pending;

        w_rreq       = '0;
        w_rreq.s     = (r_lo > r_rp) ? r_lo : r_rp;
        w_rreq.e     = r_hi;
        w_rreq.rp    = r_rp;
        w_preq         = '0;
        w_preq.last_id = r_next_id + ctc_pkg::ID_W'(r_idc) - 1'b1;
        w_preq.size    = r_bytes;
        w_preq.rp      = r_rp;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd      = i_in.command;
                    n_idc      = i_in.id_count;
                    n_bytes    = i_in.pin_bytes;
                    n_lo32     = i_in.range_low;
                    n_hi32     = i_in.range_high;
                    n_copied   = i_in.was_copied;
                    n_status   = ctc_pkg::ST_OK;
                    n_fallback = '0;
                    n_dropped  = '0;
                    n_popped   = 1'b0;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_OUT;
                unique case (r_cmd)
                    ctc_pkg::CMD_SUBMIT: begin
                        if (r_idc != '0) begin
                            if (w_prsp.count == ctc_pkg::PIN_FULL) begin
                                n_status = ctc_pkg::ST_PIN_FULL;
                            end else begin
                                w_preq.push = 1'b1;
                                n_next_id   = r_next_id + ctc_pkg::ID_W'(r_idc);
                            end
                        end
                    end
                    ctc_pkg::CMD_NOTICE: begin
                        n_lo    = w_lo;
                        n_hi    = w_hi;
                        n_state = S_CHECK;
                    end
                    ctc_pkg::CMD_CLOSE: begin
                        n_dropped    = 7'(w_prsp.count);
                        w_preq.clear = 1'b1;
                        w_rreq.clear = 1'b1;
                    end
                    default: n_status = ctc_pkg::ST_MALFORMED;
                endcase
            end
            S_CHECK: begin
                if (r_hi < r_lo) begin
                    n_status = ctc_pkg::ST_MALFORMED;
                    n_state  = S_OUT;
                end else begin
                    if (r_copied) begin
                        n_fallback = 33'(r_hi - r_lo) + 1'b1;
                    end
                    if (r_hi < r_rp) begin
                        n_status = ctc_pkg::ST_RETIRED;
                        n_state  = S_OUT;
                    end else begin
                        w_rreq.start = 1'b1;
                        n_state      = S_MERGE;
                    end
                end
            end
            S_MERGE: begin
                if (w_rrsp.done) begin
                    if (w_rrsp.ovf) begin
                        n_status = ctc_pkg::ST_RANGE_FULL;
                        n_state  = S_OUT;
                    end else begin
                        if (w_rrsp.first) begin
                            n_rp = w_rrsp.new_rp;
                        end
                        w_preq.pop = 1'b1;
                        n_popped   = 1'b1;
                        n_state    = S_POP;
                    end
                end
            end
            S_POP: begin
                if (w_prsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid     = 1'b1;
                    n_o_status    = r_status;
                    n_o_completed = r_popped ? 7'(w_prsp.completed) : '0;
                    n_o_retired   = r_popped ? w_prsp.retired : '0;
                    n_o_fallback  = r_fallback;
                    n_o_dropped   = r_dropped;
                    n_o_pinned    = w_prsp.pinned;
                    n_o_pending   = 7'(w_prsp.count);
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_next_id <= '0;
            r_rp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_next_id <= n_next_id;
            r_rp      <= n_rp;
            r_o_valid <= n_o_valid;
        end
        r_cmd         <= n_cmd;
        r_idc         <= n_idc;
        r_bytes       <= n_bytes;
        r_lo32        <= n_lo32;
        r_hi32        <= n_hi32;
        r_copied      <= n_copied;
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_status      <= n_status;
        r_fallback    <= n_fallback;
        r_dropped     <= n_dropped;
        r_popped      <= n_popped;
        r_o_status    <= n_o_status;
        r_o_completed <= n_o_completed;
        r_o_retired   <= n_o_retired;
        r_o_fallback  <= n_o_fallback;
        r_o_dropped   <= n_o_dropped;
        r_o_pinned    <= n_o_pinned;
        r_o_pending   <= n_o_pending;
    end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks the zero-copy completion tracker against a built-in predictor.
// Directed words cover the reset state, extremes, malformed and full cases;
// random traffic of all four commands with random gaps on both sides follows.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  id_count;
        logic [31:0] pin_bytes;
        logic [31:0] range_low;
        logic [31:0] range_high;
        logic        was_copied;
    } t_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  pins_completed;
        logic [47:0] bytes_retired;
        logic [32:0] fallback_ids;
        logic [6:0]  pins_dropped;
        logic [47:0] pinned_total;
        logic [6:0]  pending_pins;
    } t_result;

    typedef struct {
        t_word   w;
        logic    typed;
        t_result r;
    } t_row;

    localparam logic [1:0] CMD_BAD = 2'd3;
    localparam logic [47:0] BYTES_MAX = 48'hffff_ffff_ffff;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM = 1350;
    localparam int EXP_DEPTH = 256;

    logic i_clk;
    logic i_rst_n;
    ctc_in_if  in_ch();
    ctc_out_if out_ch();

    zerocopy_completion_tracker i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic [63:0] nxt_id;
    logic [63:0] rpoint;
    logic [63:0] rs [ctc_pkg::RANGE_DEPTH];
    logic [63:0] re [ctc_pkg::RANGE_DEPTH];
    int          rng_n;
    logic [63:0] pin_last [ctc_pkg::PIN_DEPTH];
    logic [31:0] pin_size [ctc_pkg::PIN_DEPTH];
    int          pin_hd;
    int          pin_n;
    logic [47:0] pinned;

    t_result exp_mem [EXP_DEPTH];
    int      exp_rd;
    int      exp_wr;
    int      exp_cnt;
    int      errors;
    int      idle_cycles;
    int      rx_wait;
    bit      stim_done;

    task automatic report(input string what, input longint got, input longint want);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [63:0] widen(input logic [31:0] id32);
        logic [63:0] v;
        v = {rpoint[63:32], id32};
        if (v < rpoint) v = v + ctc_pkg::ID_WRAP;
        return v;
    endfunction

    function automatic logic [2:0] merge_range(input logic [63:0] s, input logic [63:0] e);
        logic [63:0] ts [ctc_pkg::RANGE_DEPTH+1];
        logic [63:0] te [ctc_pkg::RANGE_DEPTH+1];
        logic [63:0] ms [ctc_pkg::RANGE_DEPTH+1];
        logic [63:0] me [ctc_pkg::RANGE_DEPTH+1];
        bit placed;
        int first;
        int k;
        int m;
        placed = 0;
        first = 0;
        k = 0;
        m = 0;
        for (int i = 0; i < rng_n; i++) begin
            if (!placed && rs[i] > s) begin
                ts[k] = s; te[k] = e; k++; placed = 1;
            end
            ts[k] = rs[i]; te[k] = re[i]; k++;
        end
        if (!placed) begin
            ts[k] = s; te[k] = e; k++;
        end
        for (int i = 0; i < k; i++) begin
            if (m > 0 && (me[m-1] == '1 || ts[i] <= me[m-1] + 64'd1)) begin
                if (te[i] > me[m-1]) me[m-1] = te[i];
            end else begin
                ms[m] = ts[i]; me[m] = te[i]; m++;
            end
        end
        if (m > 0 && ms[0] <= rpoint) first = 1;
        if (m - first > ctc_pkg::RANGE_DEPTH) return ctc_pkg::ST_RANGE_FULL;
        if (first != 0) rpoint = me[0] + 64'd1;
        rng_n = m - first;
        for (int i = 0; i < rng_n; i++) begin
            rs[i] = ms[i + first];
            re[i] = me[i + first];
        end
        return ctc_pkg::ST_OK;
    endfunction

    function automatic t_result track_word(input t_word w);
        t_result r;
        logic [63:0] lo, hi;
        logic [48:0] sum;
        int slot;
        r = '{default: '0};
        case (w.command)
            ctc_pkg::CMD_SUBMIT: begin
                if (w.id_count != 0) begin
                    if (pin_n >= ctc_pkg::PIN_DEPTH) begin
                        r.status = ctc_pkg::ST_PIN_FULL;
                    end else begin
                        slot = (pin_hd + pin_n) % ctc_pkg::PIN_DEPTH;
                        pin_last[slot] = nxt_id + w.id_count - 64'd1;
                        pin_size[slot] = w.pin_bytes;
                        pin_n++;
                        nxt_id = nxt_id + w.id_count;
                        sum = pinned + w.pin_bytes;
                        pinned = sum[48] ? BYTES_MAX : sum[47:0];
                    end
                end
            end
            ctc_pkg::CMD_NOTICE: begin
                lo = widen(w.range_low);
                hi = widen(w.range_high);
                if (hi < lo) begin
                    r.status = ctc_pkg::ST_MALFORMED;
                end else begin
                    if (w.was_copied) r.fallback_ids = 33'(hi - lo + 64'd1);
                    if (hi < rpoint) begin
                        r.status = ctc_pkg::ST_RETIRED;
                    end else begin
                        r.status = merge_range(lo > rpoint ? lo : rpoint, hi);
                        if (r.status == ctc_pkg::ST_OK) begin
                            while (pin_n > 0 && pin_last[pin_hd] < rpoint) begin
                                r.pins_completed++;
                                r.bytes_retired += pin_size[pin_hd];
                                pinned = pinned >= pin_size[pin_hd]
                                       ? pinned - pin_size[pin_hd] : '0;
                                pin_hd = (pin_hd + 1) % ctc_pkg::PIN_DEPTH;
                                pin_n--;
                            end
                        end
                    end
                end
            end
            ctc_pkg::CMD_CLOSE: begin
                r.pins_dropped = 7'(pin_n);
                pin_hd = 0;
                pin_n = 0;
                pinned = '0;
                rng_n = 0;
            end
            default: r.status = ctc_pkg::ST_MALFORMED;
        endcase
        r.pinned_total = pinned;
        r.pending_pins = 7'(pin_n);
        return r;
    endfunction

    task automatic send_word(input t_word w, input logic typed, input t_result want);
        t_result p;
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= w.command;
        in_ch.id_count   <= w.id_count;
        in_ch.pin_bytes  <= w.pin_bytes;
        in_ch.range_low  <= w.range_low;
        in_ch.range_high <= w.range_high;
        in_ch.was_copied <= w.was_copied;
        do @(posedge i_clk); while (!in_ch.ready);
        p = track_word(w);
        if (typed && p != want) begin
            report("table row vs predictor", p.status, want.status);
        end
        exp_mem[exp_wr] = typed ? want : p;
        exp_wr = (exp_wr + 1) % EXP_DEPTH;
        exp_cnt++;
    endtask

    // drops valid right after an accepted word, before the sender pauses
    task automatic stop_input();
        in_ch.valid <= 1'b0;
    endtask

    function automatic t_word mk(input logic [1:0] c, input logic [7:0] n,
                                 input logic [31:0] b, input logic [31:0] lo,
                                 input logic [31:0] hi, input logic cp);
        t_word w;
        w = '{c, n, b, lo, hi, cp};
        return w;
    endfunction

    function automatic t_result res(input logic [2:0] st, input logic [32:0] fb,
                                    input logic [6:0] dr, input logic [47:0] pt,
                                    input logic [6:0] pp);
        t_result r;
        r = '{default: '0};
        r.status = st; r.fallback_ids = fb; r.pins_dropped = dr;
        r.pinned_total = pt; r.pending_pins = pp;
        return r;
    endfunction

    // receiver: takes each result after a random wait and checks it against the expected queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (exp_cnt == 0) begin
                    report("unexpected result", out_ch.status, 0);
                end else begin
                    t_result e;
                    e = exp_mem[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_cnt--;
                    if (out_ch.status !== e.status)
                        report("status", out_ch.status, e.status);
                    if (out_ch.pins_completed !== e.pins_completed)
                        report("pins_completed", out_ch.pins_completed, e.pins_completed);
                    if (out_ch.bytes_retired !== e.bytes_retired)
                        report("bytes_retired", out_ch.bytes_retired, e.bytes_retired);
                    if (out_ch.fallback_ids !== e.fallback_ids)
                        report("fallback_ids", out_ch.fallback_ids, e.fallback_ids);
                    if (out_ch.pins_dropped !== e.pins_dropped)
                        report("pins_dropped", out_ch.pins_dropped, e.pins_dropped);
                    if (out_ch.pinned_total !== e.pinned_total)
                        report("pinned_total", out_ch.pinned_total, e.pinned_total);
                    if (out_ch.pending_pins !== e.pending_pins)
                        report("pending_pins", out_ch.pending_pins, e.pending_pins);
                end
                rx_wait = stim_done ? 0 : $urandom_range(0, 11);
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
            out_ch.ready <= (rx_wait == 0);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    t_row dir_rows [$];

    initial begin
        t_word w;
        int kind;
        logic [31:0] base, lo32, hi32;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.command = ctc_pkg::CMD_SUBMIT;
        in_ch.id_count = '0;
        in_ch.pin_bytes = '0;
        in_ch.range_low = '0;
        in_ch.range_high = '0;
        in_ch.was_copied = 1'b0;
        errors = 0;
        stim_done = 0;
        exp_rd = 0; exp_wr = 0; exp_cnt = 0;
        rng_n = 0; pin_hd = 0; pin_n = 0;
        nxt_id = '0; rpoint = '0; pinned = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        dir_rows = '{
            '{mk(ctc_pkg::CMD_CLOSE, 0, 0, 0, 0, 0), 1, res(ctc_pkg::ST_OK, 0, 0, 0, 0)},
            '{mk(ctc_pkg::CMD_SUBMIT, 0, '1, 0, 0, 0), 1, res(ctc_pkg::ST_OK, 0, 0, 0, 0)},
            '{mk(CMD_BAD, '1, '1, '1, '1, 1), 1, res(ctc_pkg::ST_MALFORMED, 0, 0, 0, 0)},
            '{mk(ctc_pkg::CMD_NOTICE, 0, 0, 5, 4, 1), 1,
              res(ctc_pkg::ST_MALFORMED, 0, 0, 0, 0)},
            '{mk(ctc_pkg::CMD_SUBMIT, '1, '1, 0, 0, 0), 1,
              res(ctc_pkg::ST_OK, 0, 0, 48'hffff_ffff, 1)},
            '{mk(ctc_pkg::CMD_SUBMIT, 1, '1, 0, 0, 0), 0, '{default: '0}},
            '{mk(ctc_pkg::CMD_NOTICE, 0, 0, 300, 400, 1), 0, '{default: '0}},
            '{mk(ctc_pkg::CMD_NOTICE, 0, 0, 0, 100, 0), 0, '{default: '0}},
            '{mk(ctc_pkg::CMD_NOTICE, 0, 0, 101, 299, 1), 0, '{default: '0}},
            '{mk(ctc_pkg::CMD_NOTICE, 0, 0, 10, 20, 1), 0, '{default: '0}},
            '{mk(ctc_pkg::CMD_SUBMIT, 3, 0, 0, 0, 0), 0, '{default: '0}},
            '{mk(ctc_pkg::CMD_NOTICE, 0, 0, 0, '1, 1), 0, '{default: '0}},
            '{mk(ctc_pkg::CMD_NOTICE, 0, 0, '1, '1, 0), 0, '{default: '0}},
            '{mk(ctc_pkg::CMD_SUBMIT, 2, 32'h5555_aaaa, 0, 0, 0), 0, '{default: '0}},
            '{mk(ctc_pkg::CMD_CLOSE, 0, 0, 0, 0, 0), 0, '{default: '0}}
        };
        foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].r);

        // range table overflow: seventeen disjoint single-id ranges above retire point
        base = rpoint[31:0];
        for (int k = 0; k < 17; k++) begin
            w = mk(ctc_pkg::CMD_NOTICE, 0, 0, base + 2 + 2 * k, base + 2 + 2 * k, 1);
            send_word(w, 0, '{default: '0});
        end
        // pin queue full
        for (int k = 0; k < 66; k++) begin
            w = mk(ctc_pkg::CMD_SUBMIT, 8'($urandom_range(1, 255)), '1, 0, 0, 0);
            send_word(w, 0, '{default: '0});
        end
        w = mk(ctc_pkg::CMD_NOTICE, 0, 0, rpoint[31:0], 32'(nxt_id), 1);
        send_word(w, 0, '{default: '0});

        stop_input();
        wait (exp_cnt == 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 99);
            w = mk(ctc_pkg::CMD_SUBMIT, 0, 0, 0, 0, 1'($urandom));
            if (kind < 45) begin
                w.id_count = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                             8'($urandom_range(1, 8));
                w.pin_bytes = ($urandom_range(0, 9) == 0)
                              ? 32'hffff_ffff - 32'($urandom_range(0, 3))
                              : $urandom;
                if ($urandom_range(0, 30) == 0) w.id_count = 0;
            end else if (kind < 93) begin
                w.command = ctc_pkg::CMD_NOTICE;
                if (kind < 85) begin
                    // mostly plausible ranges around the open window
                    lo32 = rpoint[31:0] + 32'($urandom_range(0, 40)) - 32'($urandom_range(0, 6));
                    hi32 = lo32 + 32'($urandom_range(0, 12));
                end else begin
                    lo32 = $urandom;
                    hi32 = ($urandom_range(0, 1) == 0) ? $urandom : lo32 + 32'($urandom);
                end
                w.range_low = lo32;
                w.range_high = hi32;
            end else if (kind < 97) begin
                w.command = ctc_pkg::CMD_CLOSE;
                w.id_count = 8'($urandom); w.pin_bytes = $urandom;
            end else begin
                w.command = CMD_BAD;
                w.range_low = $urandom; w.range_high = $urandom;
            end
            send_word(w, 0, '{default: '0});
            if (n == N_RANDOM / 2) begin
                stop_input();
                wait (exp_cnt == 0);
            end
        end

        stop_input();
        stim_done = 1;
        wait (exp_cnt == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[zerocopy_completion_tracker.f]
rtl/ctc_pkg.sv
rtl/ctc_if.sv
rtl/ctc_ram.sv
rtl/ctc_range_merge.sv
rtl/ctc_pin_queue.sv
rtl/zerocopy_completion_tracker.sv
bench/tb.sv
